FILE: hw/rtl/bbs_pkg.sv
// shared types, constants and helpers of the bitmap bit search block
package bbs_pkg;

    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = 64;

    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int MAP_BITS  = MAP_WORDS * WORD_BITS;
    localparam int MAP_BW    = $clog2(MAP_BITS + 1);
    localparam int CNT_W     = 13;
    localparam int BASE_W    = (MAP_BW > CNT_W) ? MAP_BW : CNT_W;
    localparam int START_W   = 12;
    localparam int IDX_W     = 6;
    localparam int DATA_W    = 64;
    localparam int CFG_IDX_W = 1;

    // start / WORD_BITS as a multiply by a rounded-up reciprocal, exact for 12-bit starts
    localparam int DIV_SH    = START_W + 7;
    localparam int DIV_MUL   = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int DIV_PW    = 32;

    localparam int BYTES     = WORD_BITS / 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_SWAP = 1'b1;

    typedef enum logic [2:0] {
        REQ_WR_A  = 3'd0,
        REQ_WR_B  = 3'd1,
        REQ_FIRST = 3'd2,
        REQ_LAST  = 3'd3,
        REQ_NEXT  = 3'd4,
        REQ_PREV  = 3'd5,
        REQ_RSV6  = 3'd6,
        REQ_RSV7  = 3'd7
    } req_type_t;

    typedef struct packed {
        logic             use_b;
        logic             inv;
        logic             swap;
        logic             dir_up;
        logic             first;
        logic [BIT_W-1:0] sb;
    } eval_ctrl_t;

    function automatic logic [WORD_BITS-1:0] swap_bytes(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] r;
        r = v;
        for (int i = 0; i < BYTES; i++) begin
            r[(BYTES - 1 - i) * 8 +: 8] = v[i * 8 +: 8];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/bbs_ram.sv
// generic single-write, single-read memory with registered read data
module bbs_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/bbs_word_eval.sv
// conditions one bitmap word and finds its lowest or highest matching bit
module bbs_word_eval
    import bbs_pkg::*;
(
    input  logic [WORD_BITS-1:0] a_word,
    input  logic [WORD_BITS-1:0] b_word,
    input  eval_ctrl_t           ctrl,
    input  logic [BASE_W-1:0]    base,
    input  logic [CNT_W-1:0]     limit,
    output logic                 hit,
    output logic [BIT_W-1:0]     bit_idx
);

    localparam logic [WORD_BITS-1:0] ALL = {WORD_BITS{1'b1}};

    logic [WORD_BITS-1:0] v_and;
    logic [WORD_BITS-1:0] v_inv;
    logic [WORD_BITS-1:0] v_swp;
    logic [WORD_BITS-1:0] valid_mask;
    logic [WORD_BITS-1:0] start_mask;
    logic [WORD_BITS-1:0] v_fin;
    logic [BASE_W-1:0]    limit_ext;
    logic [BASE_W-1:0]    span;

    always_comb begin
        v_and = ctrl.use_b ? (a_word & b_word) : a_word;
        v_inv = ctrl.inv ? ~v_and : v_and;
        v_swp = ctrl.swap ? swap_bytes(v_inv) : v_inv;

        // keep only positions below the limit
        limit_ext = BASE_W'(limit);
        span      = limit_ext - base;
        if (limit_ext <= base) begin
            valid_mask = '0;
        end else if (span >= BASE_W'(WORD_BITS)) begin
            valid_mask = ALL;
        end else begin
            valid_mask = ~(ALL << span[BIT_W-1:0]);
        end

        if (!ctrl.first) begin
            start_mask = ALL;
        end else if (ctrl.dir_up) begin
            start_mask = ALL << ctrl.sb;
        end else begin
            start_mask = ALL >> (BIT_W'(WORD_BITS - 1) - ctrl.sb);
        end

        v_fin = v_swp & valid_mask & start_mask;
        hit   = |v_fin;

        bit_idx = '0;
        if (ctrl.dir_up) begin
            for (int i = WORD_BITS - 1; i >= 0; i--) begin
                if (v_fin[i]) begin
                    bit_idx = BIT_W'(i);
                end
            end
        end else begin
            for (int i = 0; i < WORD_BITS; i++) begin
                if (v_fin[i]) begin
                    bit_idx = BIT_W'(i);
                end
            end
        end
    end

endmodule

FILE: hw/rtl/bitmap_bit_search.sv
// Bitmap bit search: two bitmaps of MAP_WORDS words held in one-port-write, one-port-read
// memories, written one word per write request; a write leaves the block idle. A query
// passes the setup states ST_DIV and ST_INIT (start word computation), the memory read
// latency, then visits one word per cycle, walking the words in order from the start word,
// and loads the output register in ST_RESP. A miss is detected once the last word of the
// walk is evaluated, and a next or prev whose start lies at or past the range skips the walk.
// The next request can be taken in the cycle after the result is loaded. The rate is set by
// the single read port of each map, read once per word. The result waits in an output
// register, so the next request is taken while it is pending. The user is to write
// bit_count and byte_swap over the cfg channel only while the block is idle; the block
// itself does not enforce this.
module bitmap_bit_search
    import bbs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_req_type,
    input  logic [IDX_W-1:0]     s_word_index,
    input  logic [DATA_W-1:0]    s_word_data,
    input  logic [START_W-1:0]   s_start_bit,
    input  logic                 s_find_zero,
    input  logic                 s_use_mask_map,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CNT_W-1:0]     m_bit_position,
    output logic                 m_found,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_INIT = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_RESP = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   bit_count_reg;
    logic               byte_swap_reg;

    req_type_t          req_reg, req_next;
    logic [START_W-1:0] start_reg, start_next;
    logic               inv_reg, inv_next;
    logic               use_b_reg, use_b_next;
    logic [CNT_W-1:0]   limit_reg, limit_next;
    logic [START_W-1:0] quot_reg, quot_next;

    logic [ADDR_W-1:0]  issue_w_reg, issue_w_next;
    logic               issue_live_reg, issue_live_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [BASE_W-1:0]  base_reg, base_next;
    logic               first_reg, first_next;
    logic [BIT_W-1:0]   sb_reg, sb_next;

    logic [CNT_W-1:0]   res_pos_reg, res_pos_next;
    logic               res_found_reg, res_found_next;
    logic               m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]   m_pos_reg, m_pos_next;
    logic               m_found_reg, m_found_next;

    logic               s_fire;
    req_type_t          s_req;
    logic               wr_a_en;
    logic               wr_b_en;
    logic               wr_in_range;
    logic               dir_up;
    logic               at_end;
    logic [DIV_PW-1:0]  div_prod;
    logic [WORD_BITS-1:0] rd_a;
    logic [WORD_BITS-1:0] rd_b;
    eval_ctrl_t         ev_ctrl;
    logic               ev_hit;
    logic [BIT_W-1:0]   ev_bit;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign s_req     = req_type_t'(s_req_type);

    assign wr_in_range = (int'(s_word_index) < MAP_WORDS);
    assign wr_a_en     = s_fire && (s_req == REQ_WR_A) && wr_in_range;
    assign wr_b_en     = s_fire && (s_req == REQ_WR_B) && wr_in_range;

    assign dir_up = (req_reg == REQ_FIRST) || (req_reg == REQ_NEXT);
    assign at_end = dir_up ? (issue_w_reg == ADDR_W'(MAP_WORDS - 1)) : (issue_w_reg == '0);

    assign div_prod = DIV_PW'(start_reg) * DIV_PW'(DIV_MUL);

    bbs_ram #(
        .DATA_W (WORD_BITS),
        .DEPTH  (MAP_WORDS),
        .ADDR_W (ADDR_W)
    ) u_map_a (
        .aclk    (aclk),
        .wr_en   (wr_a_en),
        .wr_addr (ADDR_W'(s_word_index)),
        .wr_data (WORD_BITS'(s_word_data)),
        .rd_addr (issue_w_reg),
        .rd_data (rd_a)
    );

    bbs_ram #(
        .DATA_W (WORD_BITS),
        .DEPTH  (MAP_WORDS),
        .ADDR_W (ADDR_W)
    ) u_map_b (
        .aclk    (aclk),
        .wr_en   (wr_b_en),
        .wr_addr (ADDR_W'(s_word_index)),
        .wr_data (WORD_BITS'(s_word_data)),
        .rd_addr (issue_w_reg),
        .rd_data (rd_b)
    );

    always_comb begin
        ev_ctrl.use_b  = use_b_reg;
        ev_ctrl.inv    = inv_reg;
        ev_ctrl.swap   = byte_swap_reg;
        ev_ctrl.dir_up = dir_up;
        ev_ctrl.first  = first_reg;
        ev_ctrl.sb     = sb_reg;
    end

    bbs_word_eval u_eval (
        .a_word  (rd_a),
        .b_word  (rd_b),
        .ctrl    (ev_ctrl),
        .base    (base_reg),
        .limit   (limit_reg),
        .hit     (ev_hit),
        .bit_idx (ev_bit)
    );

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        start_next      = start_reg;
        inv_next        = inv_reg;
        use_b_next      = use_b_reg;
        limit_next      = limit_reg;
        quot_next       = quot_reg;
        issue_w_next    = issue_w_reg;
        issue_live_next = issue_live_reg;
        rd_pend_next    = 1'b0;
        base_next       = base_reg;
        first_next      = first_reg;
        sb_next         = sb_reg;
        res_pos_next    = res_pos_reg;
        res_found_next  = res_found_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    req_next   = s_req;
                    start_next = s_start_bit;
                    inv_next   = s_find_zero;
                    use_b_next = s_use_mask_map &&
                                 ((s_req == REQ_NEXT) || (s_req == REQ_PREV));
                    limit_next = (int'(bit_count_reg) < MAP_BITS) ?
                                 bit_count_reg : CNT_W'(MAP_BITS);
                    case (s_req)
                        REQ_FIRST, REQ_LAST, REQ_NEXT, REQ_PREV: state_next = ST_DIV;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV: begin
                quot_next  = div_prod[DIV_SH +: START_W];
                state_next = ST_INIT;
            end
            ST_INIT: begin
                issue_live_next = 1'b1;
                first_next      = 1'b1;
                state_next      = ST_SCAN;
                case (req_reg)
                    REQ_FIRST: begin
                        issue_w_next = '0;
                        base_next    = '0;
                        sb_next      = '0;
                    end
                    REQ_LAST: begin
                        issue_w_next = ADDR_W'(MAP_WORDS - 1);
                        base_next    = BASE_W'((MAP_WORDS - 1) * WORD_BITS);
                        sb_next      = BIT_W'(WORD_BITS - 1);
                    end
                    default: begin
                        issue_w_next = ADDR_W'(quot_reg);
                        base_next    = BASE_W'(32'(quot_reg) * WORD_BITS);
                        sb_next      = BIT_W'(32'(start_reg) - 32'(quot_reg) * WORD_BITS);
                        // start at or past the searchable range never hits
                        if ({1'b0, start_reg} >= limit_reg) begin
                            res_pos_next   = bit_count_reg;
                            res_found_next = 1'b0;
                            state_next     = ST_RESP;
                        end
                    end
                endcase
            end
            ST_SCAN: begin
                if (rd_pend_reg && ev_hit) begin
                    res_pos_next   = CNT_W'(base_reg + BASE_W'(ev_bit));
                    res_found_next = 1'b1;
                    state_next     = ST_RESP;
                end else begin
                    if (rd_pend_reg) begin
                        first_next = 1'b0;
                        base_next  = dir_up ? base_reg + BASE_W'(WORD_BITS)
                                            : base_reg - BASE_W'(WORD_BITS);
                    end
                    // reads stream one word per cycle ahead of the evaluation
                    if (issue_live_reg) begin
                        rd_pend_next    = 1'b1;
                        issue_live_next = !at_end;
                        if (!at_end) begin
                            issue_w_next = dir_up ? issue_w_reg + 1'b1 : issue_w_reg - 1'b1;
                        end
                    end else if (!rd_pend_reg) begin
                        res_pos_next   = bit_count_reg;
                        res_found_next = 1'b0;
                        state_next     = ST_RESP;
                    end
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_pos_next   = m_pos_reg;
        m_found_next = m_found_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if ((state_reg == ST_RESP) && (!m_valid_reg || m_ready)) begin
            m_valid_next = 1'b1;
            m_pos_next   = res_pos_reg;
            m_found_next = res_found_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            bit_count_reg  <= CNT_W'(4096);
            byte_swap_reg  <= 1'b0;
            issue_live_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issue_live_reg <= issue_live_next;
            rd_pend_reg    <= rd_pend_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_BIT_COUNT: bit_count_reg <= cfg_data;
                    CFG_BYTE_SWAP: byte_swap_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        start_reg     <= start_next;
        inv_reg       <= inv_next;
        use_b_reg     <= use_b_next;
        limit_reg     <= limit_next;
        quot_reg      <= quot_next;
        issue_w_reg   <= issue_w_next;
        base_reg      <= base_next;
        first_reg     <= first_next;
        sb_reg        <= sb_next;
        res_pos_reg   <= res_pos_next;
        res_found_reg <= res_found_next;
        m_pos_reg     <= m_pos_next;
        m_found_reg   <= m_found_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_bit_position = m_pos_reg;
    assign m_found        = m_found_reg;

    // a found position always lies inside the searched range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && res_found_reg) |-> (res_pos_reg < limit_reg))
        else $error("found position beyond limit");

    // a query request always enters the setup path
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_req == REQ_FIRST || s_req == REQ_LAST ||
                    s_req == REQ_NEXT || s_req == REQ_PREV)) |=> (state_reg == ST_DIV))
        else $error("query request not started");

    // memory reads stay inside the map while scanning
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (int'(issue_w_reg) < MAP_WORDS))
        else $error("word address out of range");

    // the output register is only reloaded when free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_pos_reg)))
        else $error("pending result overwritten");

endmodule
